[rtl/ctint_pkg.sv]
// ----------------------------------------------------------------------------
// ctint_pkg
// Shared widths, codes, state type and control struct for the cumulative
// table interpolator.
// ----------------------------------------------------------------------------
package ctint_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int FRAC_W = 17;
    localparam int RAD_W  = 24;
    localparam int DIAM_W = 25;

    // stream payload packing
    localparam int IN_FIELDS_W = FRAC_W + RAD_W + DIAM_W + FRAC_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((DIAM_W + 7) / 8) * 8;

    // interpolation arithmetic
    localparam int MUL_W  = (RAD_W + 1) + (FRAC_W + 1);  // signed dr * dq
    localparam int PROD_W = MUL_W + 1;                   // times two
    localparam int MAG_W  = PROD_W - 1;                  // magnitude of product
    localparam int SUM_W  = MAG_W + 3;                   // 2*r_lo +/- quotient

    localparam logic [DIAM_W-1:0] DIAM_MAX  = '1;
    localparam logic [DIAM_W-1:0] TOL_RESET = DIAM_W'(1);

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_ANSWER = 2'd0;
    localparam logic [STAT_W-1:0] ST_STORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FEW    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_RDHI,
        S_RDLO,
        S_CAPLO,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_SUM,
        S_CLAMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
    } t_tbl_cmd;

endpackage

[rtl/ctint_table.sv]
// ----------------------------------------------------------------------------
// ctint_table
// Fraction and radius stores with one write port (append) and one registered
// read port, plus the entry count and a copy of the first radius.
// ----------------------------------------------------------------------------
module ctint_table #(
    parameter int TABLE_DEPTH = ctint_pkg::TABLE_DEPTH_DEF,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
    localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ctint_pkg::t_tbl_cmd          i_cmd,
    input  logic [ctint_pkg::FRAC_W-1:0] i_frac,
    input  logic [ctint_pkg::RAD_W-1:0]  i_rad,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [ctint_pkg::FRAC_W-1:0] o_rd_frac,
    output logic [ctint_pkg::RAD_W-1:0]  o_rd_rad,
    output logic [CNT_W-1:0]             o_count,
    output logic [ctint_pkg::RAD_W-1:0]  o_first_rad
);
    import ctint_pkg::*;

    logic [FRAC_W-1:0] r_frac_mem [TABLE_DEPTH];
    logic [RAD_W-1:0]  r_rad_mem  [TABLE_DEPTH];
    logic [FRAC_W-1:0] r_rd_frac;
    logic [RAD_W-1:0]  r_rd_rad;
    logic [RAD_W-1:0]  r_first_rad;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_full;
    logic              w_wr;

    assign w_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_wr   = i_cmd.append && !i_cmd.clear && !w_full;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (w_wr) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_frac_mem[r_count[ADDR_W-1:0]] <= i_frac;
            r_rad_mem[r_count[ADDR_W-1:0]]  <= i_rad;
        end
        r_rd_frac <= r_frac_mem[i_rd_addr];
        r_rd_rad  <= r_rad_mem[i_rd_addr];
    end

    // entry 0 radius kept aside: floor value needed without a read
    always_ff @(posedge i_clk) begin
        if (w_wr && (r_count == '0)) begin
            r_first_rad <= i_rad;
        end
    end

    assign o_rd_frac   = r_rd_frac;
    assign o_rd_rad    = r_rd_rad;
    assign o_count     = r_count;
    assign o_first_rad = r_first_rad;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance the count");

endmodule

[rtl/ctint_div.sv]
// ----------------------------------------------------------------------------
// ctint_div
// Restoring unsigned divider, one quotient bit per cycle. Reports the
// quotient and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module ctint_div #(
    parameter int NUM_W = ctint_pkg::MAG_W,
    parameter int DEN_W = ctint_pkg::FRAC_W,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_rem_nz
);
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    // remainder stays below the divisor, so DEN_W bits hold it
    assign n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_quo    = r_num;
    assign o_rem_nz = |r_rem;

endmodule

[rtl/cumulative_table_interpolator.sv]
// ----------------------------------------------------------------------------
// cumulative_table_interpolator
// Piecewise linear lookup in a table of cumulative fraction / radius pairs.
// Clear, append and short query answers appear one cycle after the transfer.
// A full query scans the entries, reading one entry a cycle through the
// single table read port, then runs a bit-serial divider unless the query
// is below the first fraction or the segment has zero fraction width.
// Reset empties the table, sets the tolerance to 1 and idles the sequencer;
// the stores themselves are not cleared.
// ----------------------------------------------------------------------------
module cumulative_table_interpolator #(
    parameter int TABLE_DEPTH = ctint_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cfg: diameter_tolerance
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctint_pkg::DIAM_W-1:0]     i_cfg_data,
    // tdata: entry_fraction, entry_radius, query_diameter, query_fraction
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ctint_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic [ctint_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: result_diameter
    output logic [ctint_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [ctint_pkg::STAT_W-1:0]     m_axis_tuser
);
    import ctint_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // input fields
    logic [FRAC_W-1:0] w_in_frac;
    logic [RAD_W-1:0]  w_in_rad;
    logic [DIAM_W-1:0] w_in_diam;
    logic [FRAC_W-1:0] w_in_q;

    assign w_in_frac = s_axis_tdata[FRAC_W-1:0];
    assign w_in_rad  = s_axis_tdata[FRAC_W+RAD_W-1:FRAC_W];
    assign w_in_diam = s_axis_tdata[FRAC_W+RAD_W+DIAM_W-1:FRAC_W+RAD_W];
    assign w_in_q    = s_axis_tdata[IN_FIELDS_W-1:FRAC_W+RAD_W+DIAM_W];

    t_state r_state;
    t_state n_state;

    logic [DIAM_W-1:0] r_tol;
    logic [FRAC_W-1:0] r_q;
    logic [ADDR_W-1:0] r_idx;
    logic              r_chk_v;
    logic [ADDR_W-1:0] r_chk_idx;
    logic [ADDR_W-1:0] r_hi;
    logic [FRAC_W-1:0] r_f_hi;
    logic [RAD_W-1:0]  r_r_hi;
    logic [FRAC_W-1:0] r_f_lo;
    logic [RAD_W-1:0]  r_r_lo;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FRAC_W:0]   r_df;
    logic              r_neg;
    logic signed [SUM_W-1:0]  r_t;
    logic [DIAM_W-1:0] r_res;
    logic              r_out_valid;
    logic [DIAM_W-1:0] r_out_diam;
    logic [STAT_W-1:0] r_out_stat;

    // table
    t_tbl_cmd          w_tbl_cmd;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [FRAC_W-1:0] w_rd_frac;
    logic [RAD_W-1:0]  w_rd_rad;
    logic [CNT_W-1:0]  w_count;
    logic [RAD_W-1:0]  w_first_rad;

    // divider
    logic              w_div_start;
    logic              w_div_busy;
    logic              w_div_done;
    logic [MAG_W-1:0]  w_div_quo;
    logic              w_div_rem_nz;

    logic              w_acc;
    logic              w_out_free;
    logic              w_full;
    logic              w_few;
    logic [DIAM_W-1:0] w_floor;
    logic              w_small;
    logic              w_go_query;
    logic [DIAM_W-1:0] w_imm_diam;
    logic [STAT_W-1:0] w_imm_stat;
    logic              w_hit;
    logic              w_last;
    logic signed [RAD_W:0]    w_dr;
    logic signed [FRAC_W:0]   w_dq;
    logic signed [MUL_W-1:0]  w_mul;
    logic signed [PROD_W-1:0] w_pneg;
    logic [MAG_W-1:0]  w_pmag;
    logic [FRAC_W:0]   w_dneg;
    logic [FRAC_W-1:0] w_dmag;
    logic [MAG_W:0]    w_qmag;
    logic signed [SUM_W-1:0]  w_two_rlo;
    logic signed [SUM_W-1:0]  w_qext;
    logic signed [SUM_W-1:0]  w_floor_ext;
    logic signed [SUM_W-1:0]  w_max_ext;

    ctint_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_tbl_cmd),
        .i_frac      (w_in_frac),
        .i_rad       (w_in_rad),
        .i_rd_addr   (w_rd_addr),
        .o_rd_frac   (w_rd_frac),
        .o_rd_rad    (w_rd_rad),
        .o_count     (w_count),
        .o_first_rad (w_first_rad)
    );

    ctint_div #(
        .NUM_W (MAG_W),
        .DEN_W (FRAC_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_pmag),
        .i_den    (w_dmag),
        .o_busy   (w_div_busy),
        .o_done   (w_div_done),
        .o_quo    (w_div_quo),
        .o_rem_nz (w_div_rem_nz)
    );

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // decisions made at the input transfer
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_full     = (w_count == CNT_W'(TABLE_DEPTH));
    assign w_few      = (w_count < CNT_W'(2));
    assign w_floor    = {w_first_rad, 1'b0};
    assign w_small    = ({1'b0, w_in_diam} < ({1'b0, w_floor} + {1'b0, r_tol}));
    assign w_go_query = w_acc && (s_axis_tuser == KIND_QUERY) && !w_few && !w_small;

    always_comb begin
        w_imm_diam = '0;
        w_imm_stat = ST_STORED;
        case (s_axis_tuser)
            KIND_CLEAR: begin
                w_imm_stat = ST_STORED;
            end
            KIND_APPEND: begin
                w_imm_stat = w_full ? ST_FULL : ST_STORED;
            end
            KIND_QUERY: begin
                if (w_few) begin
                    w_imm_stat = ST_FEW;
                end else begin
                    w_imm_stat = ST_ANSWER;
                    w_imm_diam = w_floor;
                end
            end
            default: begin
                w_imm_stat = ST_STORED;
            end
        endcase
    end

    // scan compare: the checked entry is the one addressed in the cycle before
    assign w_hit  = r_chk_v && (w_rd_frac > r_q);
    assign w_last = r_chk_v && (CNT_W'(r_chk_idx) == (w_count - CNT_W'(2)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_go_query) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (w_hit) begin
                    n_state = (r_chk_idx == '0) ? S_DONE : S_RDHI;
                end else if (w_last) begin
                    n_state = S_RDHI;
                end
            end
            S_RDHI:  n_state = S_RDLO;
            S_RDLO:  n_state = S_CAPLO;
            S_CAPLO: n_state = S_MUL;
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: begin
                n_state = (r_df == '0) ? S_CLAMP : S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (w_div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready    = 1'b0;
        w_tbl_cmd.clear  = 1'b0;
        w_tbl_cmd.append = 1'b0;
        w_rd_addr        = '0;
        w_div_start      = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready    = w_out_free;
                w_tbl_cmd.clear  = w_acc && (s_axis_tuser == KIND_CLEAR);
                w_tbl_cmd.append = w_acc && (s_axis_tuser == KIND_APPEND);
            end
            S_SRCH:  w_rd_addr = r_idx;
            S_RDHI:  w_rd_addr = r_hi;
            S_RDLO:  w_rd_addr = r_hi - ADDR_W'(1);
            S_DIVGO: w_div_start = (r_df != '0);
            default: begin
                w_rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // interpolation arithmetic
    assign w_dr   = $signed({1'b0, r_r_hi}) - $signed({1'b0, r_r_lo});
    assign w_dq   = $signed({1'b0, r_q}) - $signed({1'b0, r_f_lo});
    assign w_mul  = w_dr * w_dq;
    assign w_pneg = -r_prod;
    assign w_pmag = r_prod[PROD_W-1] ? w_pneg[MAG_W-1:0] : r_prod[MAG_W-1:0];
    assign w_dneg = -r_df;
    assign w_dmag = r_df[FRAC_W] ? w_dneg[FRAC_W-1:0] : r_df[FRAC_W-1:0];

    // negative quotient rounds toward minus infinity
    assign w_qmag      = {1'b0, w_div_quo} + (MAG_W+1)'(r_neg && w_div_rem_nz);
    assign w_two_rlo   = $signed({{(SUM_W-RAD_W-1){1'b0}}, r_r_lo, 1'b0});
    assign w_qext      = $signed({{(SUM_W-MAG_W-1){1'b0}}, w_qmag});
    assign w_floor_ext = $signed({{(SUM_W-DIAM_W){1'b0}}, w_floor});
    assign w_max_ext   = $signed({{(SUM_W-DIAM_W){1'b0}}, DIAM_MAX});

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q       <= w_in_q;
                r_idx     <= '0;
                r_chk_v   <= 1'b0;
                r_chk_idx <= '0;
            end
            S_SRCH: begin
                r_idx     <= r_idx + ADDR_W'(1);
                r_chk_v   <= 1'b1;
                r_chk_idx <= r_idx;
                if (w_hit) begin
                    r_hi  <= r_chk_idx;
                    r_res <= w_floor;
                end else if (w_last) begin
                    r_hi <= ADDR_W'(w_count - CNT_W'(1));
                end
            end
            S_RDLO: begin
                r_f_hi <= w_rd_frac;
                r_r_hi <= w_rd_rad;
            end
            S_CAPLO: begin
                r_f_lo <= w_rd_frac;
                r_r_lo <= w_rd_rad;
            end
            S_MUL: begin
                r_prod <= {w_mul, 1'b0};
                r_df   <= $signed({1'b0, r_f_hi}) - $signed({1'b0, r_f_lo});
            end
            S_DIVGO: begin
                r_neg <= r_prod[PROD_W-1] ^ r_df[FRAC_W];
                r_t   <= w_two_rlo;
            end
            S_SUM: begin
                r_t <= r_neg ? (w_two_rlo - w_qext) : (w_two_rlo + w_qext);
            end
            S_CLAMP: begin
                if (r_t < w_floor_ext) begin
                    r_res <= w_floor;
                end else if (r_t > w_max_ext) begin
                    r_res <= DIAM_MAX;
                end else begin
                    r_res <= r_t[DIAM_W-1:0];
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_acc && !w_go_query) || ((r_state == S_DONE) && w_out_free)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_go_query) begin
            r_out_diam <= w_imm_diam;
            r_out_stat <= w_imm_stat;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_diam <= r_res;
            r_out_stat <= ST_ANSWER;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_diam);
    assign m_axis_tuser  = r_out_stat;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while a query is in progress");

    a_div_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> ((r_state == S_DIVGO) && !w_div_busy))
        else $error("divider started out of sequence");

    a_non_answer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_ANSWER)) |-> (m_axis_tdata == '0))
        else $error("non-answer transfer carries a diameter");

    a_done_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVWAIT))
        else $error("divider finished outside its wait state");

endmodule

[test/cumulative_table_interpolator_checker.sv]
// ----------------------------------------------------------------------------
// cumulative_table_interpolator_checker
// Watches the config, input and result channels of the interpolator, keeps a
// shadow table and tolerance, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cumulative_table_interpolator_checker
    import ctint_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [DIAM_W-1:0]     i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // tdata: entry_fraction, entry_radius, query_diameter, query_fraction
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: result_diameter
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status
    input  logic [STAT_W-1:0]     m_axis_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [DIAM_W-1:0] diameter;
        logic [STAT_W-1:0] status;
    } t_answer;

    logic [FRAC_W-1:0] frac_tbl [TABLE_DEPTH_DEF];
    logic [RAD_W-1:0]  rad_tbl  [TABLE_DEPTH_DEF];
    int                n_entries;
    logic [DIAM_W-1:0] tol_reg;
    t_answer           answer_q [$];
    t_answer           want;
    int                fail_cnt = 0;

    // next diameter for a query on a table of at least two entries
    function automatic logic [DIAM_W-1:0] next_diameter(input logic [DIAM_W-1:0] diam,
                                                        input logic [FRAC_W-1:0] q);
        longint floor_v, t, f_lo, f_hi, r_lo, r_hi, num, den;
        int     hi_idx;
        bit     hit;
        floor_v = 2 * longint'(rad_tbl[0]);
        if (longint'(diam) < floor_v + longint'(tol_reg))
            return DIAM_W'(floor_v);
        hi_idx = n_entries - 1;
        hit    = 1'b0;
        for (int i = 0; i + 1 < n_entries; i++) begin
            if (!hit && frac_tbl[i] > q) begin
                hi_idx = i;
                hit    = 1'b1;
            end
        end
        // query below the first fraction: nothing to interpolate from
        if (hit && hi_idx == 0)
            return DIAM_W'(floor_v);
        f_lo = longint'(frac_tbl[hi_idx-1]);
        f_hi = longint'(frac_tbl[hi_idx]);
        r_lo = longint'(rad_tbl[hi_idx-1]);
        r_hi = longint'(rad_tbl[hi_idx]);
        t    = 2 * r_lo;
        num  = 2 * (r_hi - r_lo) * (longint'(q) - f_lo);
        den  = f_hi - f_lo;
        if (den != 0) begin
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            // round toward minus infinity
            if (num >= 0)
                t += num / den;
            else
                t -= (-num + den - 1) / den;
        end
        if (t < floor_v)
            return DIAM_W'(floor_v);
        if (t > longint'(DIAM_MAX))
            return DIAM_MAX;
        return DIAM_W'(t);
    endfunction

    function automatic t_answer apply_item(input logic [KIND_W-1:0]    kind,
                                           input logic [IN_DATA_W-1:0] data);
        t_answer           a;
        logic [FRAC_W-1:0] ef, qf;
        logic [RAD_W-1:0]  er;
        logic [DIAM_W-1:0] qd;
        {qf, qd, er, ef} = data[IN_FIELDS_W-1:0];
        a.diameter = '0;
        a.status   = ST_STORED;
        case (kind)
            KIND_CLEAR: begin
                n_entries = 0;
            end
            KIND_APPEND: begin
                if (n_entries < TABLE_DEPTH_DEF) begin
                    frac_tbl[n_entries] = ef;
                    rad_tbl[n_entries]  = er;
                    n_entries++;
                end else begin
                    a.status = ST_FULL;
                end
            end
            KIND_QUERY: begin
                if (n_entries < 2) begin
                    a.status = ST_FEW;
                end else begin
                    a.diameter = next_diameter(qd, qf);
                    a.status   = ST_ANSWER;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answer_q.delete();
            n_entries = 0;
            tol_reg   = TOL_RESET;
        end else begin
            // results leave in a later cycle than their item, so pop first
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result diameter %0d status %0d",
                             $time, m_axis_tdata[DIAM_W-1:0], m_axis_tuser);
                end else begin
                    want = answer_q.pop_front();
                    if (m_axis_tdata[DIAM_W-1:0] !== want.diameter) begin
                        fail_cnt++;
                        $display("%0t: result_diameter expected %0d, got %0d",
                                 $time, want.diameter, m_axis_tdata[DIAM_W-1:0]);
                    end
                    if (m_axis_tuser !== want.status) begin
                        fail_cnt++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_axis_tuser);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                tol_reg = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                answer_q.insert(answer_q.size(), apply_item(s_axis_tuser, s_axis_tdata));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= answer_q.size();
    end

endmodule

[test/tb_cumulative_table_interpolator.sv]
// ----------------------------------------------------------------------------
// tb_cumulative_table_interpolator
// Drives clear, append and query transfers into the interpolator: a directed
// pass over the corner cases, then random tables and queries under three
// stall patterns and several tolerance settings. The checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cumulative_table_interpolator;
    import ctint_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int FRAC_ONE    = 1 << 16;
    localparam int FRAC_TOP    = (1 << FRAC_W) - 1;
    localparam int RAD_TOP     = (1 << RAD_W) - 1;
    localparam int DIAM_TOP    = (1 << DIAM_W) - 1;
    localparam int PHASE_ITEMS = 175;
    localparam int CYCLE_LIMIT = 500000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [DIAM_W-1:0]     i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = KIND_CLEAR;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent = 0;
    int cur_tol = 1;
    int first_rad = 0;
    int tbl_frac [$];

    cumulative_table_interpolator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cumulative_table_interpolator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input int ef, input int er,
                             input int qd, input int qf);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_W'({FRAC_W'(qf), DIAM_W'(qd), RAD_W'(er), FRAC_W'(ef)});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        // local view of the table, only to aim the queries
        if (kind == KIND_CLEAR) begin
            tbl_frac.delete();
        end else if (kind == KIND_APPEND && tbl_frac.size() < TABLE_DEPTH_DEF) begin
            if (tbl_frac.size() == 0)
                first_rad = er;
            tbl_frac.insert(tbl_frac.size(), ef);
        end
        if (kind != KIND_SPARE)
            items_sent++;
    endtask

    task automatic clear_table();
        send_item(KIND_CLEAR, $urandom_range(0, FRAC_TOP), $urandom_range(0, RAD_TOP),
                  $urandom_range(0, DIAM_TOP), $urandom_range(0, FRAC_TOP));
    endtask

    task automatic append(input int ef, input int er);
        send_item(KIND_APPEND, ef, er, $urandom_range(0, DIAM_TOP),
                  $urandom_range(0, FRAC_TOP));
    endtask

    task automatic query(input int qd, input int qf);
        send_item(KIND_QUERY, $urandom_range(0, FRAC_TOP), $urandom_range(0, RAD_TOP),
                  qd, qf);
    endtask

    // stop sending, wait for every result, then let the block settle
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input int value);
        drain(4);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= DIAM_W'(value);
        cur_tol = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one table load followed by a burst of queries against it
    task automatic run_sequence(input bit fill);
        int n, style, pick, nq, ef, er, qf, qd, thr;
        if (fill || $urandom_range(9) != 0)
            clear_table();
        if ($urandom_range(15) == 0)
            send_item(KIND_SPARE, $urandom_range(0, FRAC_TOP), $urandom_range(0, RAD_TOP),
                      $urandom_range(0, DIAM_TOP), $urandom_range(0, FRAC_TOP));
        pick = $urandom_range(99);
        if (fill)
            n = TABLE_DEPTH_DEF + $urandom_range(1, 2);
        else if (pick < 70)
            n = $urandom_range(2, 8);
        else if (pick < 85)
            n = $urandom_range(0, 1);
        else
            n = $urandom_range(9, 24);
        style = $urandom_range(99);
        ef = $urandom_range(0, 4000);
        er = ($urandom_range(4) != 0) ? $urandom_range(0, 4095) : $urandom_range(0, RAD_TOP);
        for (int i = 0; i < n; i++) begin
            append(ef, er);
            if (style < 75) begin
                ef += $urandom_range(1, FRAC_ONE / (n + 1));
                er += $urandom_range(0, RAD_TOP / (2 * (n + 1)));
            end else if (style < 85) begin
                // repeated fractions, jumpy radii
                ef += $urandom_range(0, 1) * $urandom_range(1, 2000);
                er = $urandom_range(0, RAD_TOP);
            end else begin
                ef = $urandom_range(0, FRAC_TOP);
                er = $urandom_range(0, RAD_TOP);
            end
            if (ef > FRAC_TOP)
                ef = FRAC_TOP;
            if (er > RAD_TOP)
                er = RAD_TOP;
        end
        nq = $urandom_range(1, 6);
        for (int i = 0; i < nq; i++) begin
            pick = (tbl_frac.size() == 0) ? $urandom_range(0, 39) : $urandom_range(99);
            if (pick < 40)
                qf = $urandom_range(0, FRAC_ONE);
            else if (pick < 65)
                qf = tbl_frac[$urandom_range(0, tbl_frac.size() - 1)] + $urandom_range(0, 2) - 1;
            else if (pick < 80)
                qf = $urandom_range(tbl_frac[$], FRAC_TOP);
            else if (pick < 90)
                qf = 0;
            else
                qf = $urandom_range(0, FRAC_TOP);
            if (qf < 0)
                qf = 0;
            if (qf > FRAC_TOP)
                qf = FRAC_TOP;
            thr = (tbl_frac.size() == 0 ? 0 : 2 * first_rad) + cur_tol;
            pick = $urandom_range(99);
            if (pick < 80 && thr <= DIAM_TOP)
                qd = $urandom_range(thr, DIAM_TOP);
            else if (pick < 90)
                qd = thr - $urandom_range(0, 1);
            else
                qd = $urandom_range(0, DIAM_TOP);
            if (qd < 0)
                qd = 0;
            if (qd > DIAM_TOP)
                qd = DIAM_TOP;
            query(qd, qf);
        end
    endtask

    initial begin
        int seq_no;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 29;
        rx_idle_pct = 55;

        // directed: table of 0 and 1 entries, then a simple ascending table
        query(1000, 0);
        append(0, 100);
        query(0, 0);
        append(32768, 1000);
        append(FRAC_ONE, RAD_TOP);
        query(0, 0);
        query(200, 12345);
        query(201, 16384);
        query(DIAM_TOP, 0);
        query(DIAM_TOP, FRAC_ONE);
        query(DIAM_TOP, FRAC_TOP);
        send_item(KIND_SPARE, FRAC_TOP, RAD_TOP, DIAM_TOP, FRAC_TOP);
        // unsorted table whose last segment has zero width
        clear_table();
        append(1000, 50);
        append(2000, RAD_TOP);
        append(500, 3000);
        append(500, 7000);
        query(DIAM_TOP, 0);
        query(DIAM_TOP, 1500);
        query(DIAM_TOP, 1000);
        query(DIAM_TOP, 40000);
        write_tolerance(DIAM_TOP);
        query(DIAM_TOP, 1500);
        write_tolerance(0);
        query(100, 1500);
        query(99, 1500);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_tolerance($urandom_range(1, 4096));
                1: write_tolerance(0);
                default: write_tolerance($urandom_range(0, 65535));
            endcase
            tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
            rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
            seq_no = 0;
            while (items_sent < 25 + PHASE_ITEMS * (phase + 1)) begin
                run_sequence((phase == 0 && seq_no == 0) || $urandom_range(19) == 0);
                seq_no++;
            end
        end

        drain(200);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
